/* rtl/btk_pkg.sv */
// btk_pkg: shared types and constants for the bounded top-k selector
// used by btk_cell and bounded_top_k_smallest; no dependencies
package btk_pkg;

    // number of cells in the chain, also the largest usable keep count
    localparam int CAPACITY = 64;

    // fixed field widths
    localparam int INDEX_W = 32;
    localparam int SCORE_W = 32;
    localparam int COUNT_W = 7;
    localparam int RANK_W  = 6;

    // keep count after reset
    localparam logic [COUNT_W-1:0] KEEP_COUNT_RESET = 7'd50;
    localparam logic [COUNT_W-1:0] KEEP_MIN         = 7'd1;
    localparam logic [COUNT_W-1:0] KEEP_MAX         = COUNT_W'(CAPACITY);

    // opcodes
    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // one held entry
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [INDEX_W-1:0]        index;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert_en;   // sorted insert of the offered entry
        logic drain_shift; // move every entry one cell toward the head
    } cell_ctrl_t;

endpackage

/* rtl/btk_cell.sv */
// btk_cell: one slot of the sorted insertion chain
// depends on btk_pkg (entry_t, cell_ctrl_t)
module btk_cell
    import btk_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       gt_prev,
    input  entry_t     new_entry,
    input  entry_t     prev_entry,
    input  entry_t     next_entry,
    output entry_t     entry,
    output logic       gt
);

    entry_t entry_reg;
    entry_t entry_next;

    // held score is worse than the offer, so the offer goes at or before this slot
    assign gt = occupied && ($signed(entry_reg.score) > $signed(new_entry.score));

    // choose between hold, shift from the left, take the offer, shift from the right
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.drain_shift)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.insert_en)
        begin
            if (gt_prev)
            begin
                entry_next = prev_entry;
            end
            else if (gt || !occupied)
            begin
                entry_next = new_entry;
            end
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* rtl/bounded_top_k_smallest.sv */
// bounded_top_k_smallest: keeps the K smallest-score offers, drains them sorted
// offer: one transfer per cycle while no drain is in progress, one compare per cell, stored at the next edge
// drain: fill_count results, one per cycle from the chain head while out_stall is low, first result
//   the cycle after the drain transfer; input stalled until the last is taken
// reset: fill count and drain control cleared, keep count set to 50;
//   cell contents are undefined until written
module bounded_top_k_smallest
    import btk_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_write,
    input  logic [COUNT_W-1:0]        cfg_data,
    // input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      opcode,
    input  logic [INDEX_W-1:0]        item_index,
    input  logic signed [SCORE_W-1:0] score,
    // output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [INDEX_W-1:0]        out_index,
    output logic signed [SCORE_W-1:0] out_score,
    output logic [RANK_W-1:0]         out_rank,
    output logic                      is_last
);

    logic [COUNT_W-1:0] keep_count_reg;
    logic [COUNT_W-1:0] fill_count_reg;
    logic [COUNT_W-1:0] fill_count_next;
    logic [RANK_W-1:0]  rank_reg;
    logic [RANK_W-1:0]  rank_next;
    logic               drain_busy_reg;
    logic               drain_busy_next;

    logic [COUNT_W-1:0] k_eff;
    logic               in_xfer;
    logic               out_xfer;
    logic               offer_xfer;
    logic               drain_xfer;
    logic               any_gt;
    logic               not_full;
    logic               last_hit;
    cell_ctrl_t         ctrl;
    entry_t             new_entry;
    entry_t             cell_entry [CAPACITY];
    logic [CAPACITY-1:0] occ_vec;
    logic [CAPACITY-1:0] gt_vec;

    // handshakes
    assign in_stall   = drain_busy_reg;
    assign out_valid  = drain_busy_reg;
    assign in_xfer    = in_valid && !in_stall;
    assign out_xfer   = out_valid && !out_stall;
    assign offer_xfer = in_xfer && (opcode == OP_OFFER);
    assign drain_xfer = in_xfer && (opcode == OP_DRAIN);

    // clamp keep count to 1..CAPACITY
    always_comb
    begin
        k_eff = keep_count_reg;
        if (keep_count_reg < KEEP_MIN)
        begin
            k_eff = KEEP_MIN;
        end
        else if (keep_count_reg > KEEP_MAX)
        begin
            k_eff = KEEP_MAX;
        end
    end

    // store is sorted, so any worse held entry means the last one is worse
    assign any_gt   = |gt_vec;
    assign not_full = fill_count_reg < k_eff;

    // command to the chain
    assign ctrl.insert_en   = offer_xfer && (not_full || any_gt);
    assign ctrl.drain_shift = out_xfer;

    assign new_entry.score = score;
    assign new_entry.index = item_index;

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign occ_vec[gi] = fill_count_reg > COUNT_W'(gi);

            if (gi == 0)
            begin : g_head
                btk_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .occupied   (occ_vec[gi]),
                    .gt_prev    (1'b0),
                    .new_entry  (new_entry),
                    .prev_entry (new_entry),
                    .next_entry (cell_entry[(gi+1) % CAPACITY]),
                    .entry      (cell_entry[gi]),
                    .gt         (gt_vec[gi])
                );
            end
            else if (gi == CAPACITY - 1)
            begin : g_tail
                btk_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .occupied   (occ_vec[gi]),
                    .gt_prev    (gt_vec[gi-1]),
                    .new_entry  (new_entry),
                    .prev_entry (cell_entry[gi-1]),
                    .next_entry (new_entry),
                    .entry      (cell_entry[gi]),
                    .gt         (gt_vec[gi])
                );
            end
            else
            begin : g_mid
                btk_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .occupied   (occ_vec[gi]),
                    .gt_prev    (gt_vec[gi-1]),
                    .new_entry  (new_entry),
                    .prev_entry (cell_entry[gi-1]),
                    .next_entry (cell_entry[gi+1]),
                    .entry      (cell_entry[gi]),
                    .gt         (gt_vec[gi])
                );
            end
        end
    endgenerate

    // result from the chain head
    assign last_hit  = ({1'b0, rank_reg} + COUNT_W'(1)) == fill_count_reg;
    assign out_index = cell_entry[0].index;
    assign out_score = cell_entry[0].score;
    assign out_rank  = rank_reg;
    assign is_last   = last_hit;

    // fill count, drain progress
    always_comb
    begin
        fill_count_next = fill_count_reg;
        rank_next       = rank_reg;
        drain_busy_next = drain_busy_reg;
        if (out_xfer)
        begin
            rank_next = rank_reg + RANK_W'(1);
            if (last_hit)
            begin
                fill_count_next = '0;
                drain_busy_next = 1'b0;
            end
        end
        else if (drain_xfer)
        begin
            rank_next = '0;
            if (fill_count_reg != '0)
            begin
                drain_busy_next = 1'b1;
            end
        end
        else if (ctrl.insert_en && not_full)
        begin
            fill_count_next = fill_count_reg + COUNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_COUNT_RESET;
            fill_count_reg <= '0;
            rank_reg       <= '0;
            drain_busy_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                keep_count_reg <= cfg_data;
            end
            fill_count_reg <= fill_count_next;
            rank_reg       <= rank_next;
            drain_busy_reg <= drain_busy_next;
        end
    end

endmodule

/* sim/btk_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// btk_scoreboard_pkg: scoreboard for the bounded top-k selector testbench,
// tracks the held entries and checks the drained results; depends on btk_pkg
package btk_scoreboard_pkg;
    import btk_pkg::*;

    // one drained entry as the output channel should carry it
    typedef struct {
        logic [INDEX_W-1:0]        index;
        logic signed [SCORE_W-1:0] score;
        logic [RANK_W-1:0]         rank;
        logic                      last;
    } ranked_entry_t;

    class topk_scoreboard;
        logic [COUNT_W-1:0]        keep_count;
        logic signed [SCORE_W-1:0] held_score [CAPACITY];
        logic [INDEX_W-1:0]        held_index [CAPACITY];
        int                        held;
        ranked_entry_t             due_entries [$];
        int                        mismatches;
        int                        transfers;
        int                        checked;

        function new();
            keep_count = KEEP_COUNT_RESET;
            held       = 0;
            mismatches = 0;
            transfers  = 0;
            checked    = 0;
        endfunction

        function void set_keep(logic [COUNT_W-1:0] value);
            keep_count = value;
        endfunction

        function int pending();
            return due_entries.size();
        endfunction

        // update the held set for one accepted input transfer
        function void note_transfer(logic op, logic [INDEX_W-1:0] idx,
                                    logic signed [SCORE_W-1:0] sc);
            int            limit;
            int            pos;
            ranked_entry_t entry;
            transfers++;
            if (op == OP_OFFER)
            begin
                // keep count clamped to 1..capacity
                limit = keep_count;
                if (limit < KEEP_MIN)
                    limit = KEEP_MIN;
                if (limit > KEEP_MAX)
                    limit = KEEP_MAX;
                // full: only a strictly smaller score displaces the last entry
                if (held >= limit)
                begin
                    if (held == 0 || sc >= held_score[held-1])
                        return;
                    held--;
                end
                // stable insert after every entry with score <= sc
                pos = held;
                while (pos > 0 && held_score[pos-1] > sc)
                begin
                    held_score[pos] = held_score[pos-1];
                    held_index[pos] = held_index[pos-1];
                    pos--;
                end
                held_score[pos] = sc;
                held_index[pos] = idx;
                held++;
            end
            else
            begin
                // drain: every held entry in order, then empty
                for (int i = 0; i < held; i++)
                begin
                    entry.index = held_index[i];
                    entry.score = held_score[i];
                    entry.rank  = RANK_W'(i);
                    entry.last  = (i + 1 == held);
                    due_entries = {due_entries, entry};
                end
                held = 0;
            end
        endfunction

        // compare one accepted output transfer with the oldest expectation
        function void check_result(logic [INDEX_W-1:0] idx, logic signed [SCORE_W-1:0] sc,
                                   logic [RANK_W-1:0] rank, logic last);
            ranked_entry_t entry;
            checked++;
            if (due_entries.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual index %h score %h",
                         $time, idx, sc);
                return;
            end
            entry = due_entries.pop_front();
            if (idx !== entry.index)
            begin
                mismatches++;
                $display("%0t: out_index rank %0d: expected %h actual %h",
                         $time, entry.rank, entry.index, idx);
            end
            if (sc !== entry.score)
            begin
                mismatches++;
                $display("%0t: out_score rank %0d: expected %h actual %h",
                         $time, entry.rank, entry.score, sc);
            end
            if (rank !== entry.rank)
            begin
                mismatches++;
                $display("%0t: out_rank: expected %0d actual %0d", $time, entry.rank, rank);
            end
            if (last !== entry.last)
            begin
                mismatches++;
                $display("%0t: is_last rank %0d: expected %b actual %b",
                         $time, entry.rank, entry.last, last);
            end
        endfunction
    endclass

endpackage

/* sim/bounded_top_k_smallest_tb.sv */
`timescale 1ns / 1ps
// bounded_top_k_smallest_tb: self-checking testbench for the top-k selector
// depends on btk_pkg, btk_scoreboard_pkg and the bounded_top_k_smallest rtl
module bounded_top_k_smallest_tb;
    import btk_pkg::*;
    import btk_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 27;
    localparam int LONG_HOLD   = 400;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [COUNT_W-1:0]        cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic                      opcode;
    logic [INDEX_W-1:0]        item_index;
    logic signed [SCORE_W-1:0] score;
    logic                      out_valid;
    logic                      out_stall;
    logic [INDEX_W-1:0]        out_index;
    logic signed [SCORE_W-1:0] out_score;
    logic [RANK_W-1:0]         out_rank;
    logic                      is_last;

    topk_scoreboard board = new();
    bit no_gaps;     // neither side idles while set
    bit hold_armed;  // receiver does one long hold once set
    int cfg_writes;
    int cycle_count;

    bounded_top_k_smallest u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .item_index (item_index),
        .score      (score),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_index  (out_index),
        .out_score  (out_score),
        .out_rank   (out_rank),
        .is_last    (is_last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: check each output transfer, random stalls, one long hold
    initial
    begin
        int hold_left;
        bit hold_done;
        out_stall <= 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.check_result(out_index, out_score, out_rank, is_last);
            if (hold_armed && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                             input logic signed [SCORE_W-1:0] sc);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        item_index <= idx;
        score      <= sc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_transfer(op, idx, sc);
    endtask

    // random offer or drain; scores often tie, sometimes hit the extremes
    task automatic send_random(input int drain_pct);
        logic signed [SCORE_W-1:0] sc;
        int                        pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            sc = SCORE_W'($urandom_range(0, 7)) - 32'sd4;
        else if (pick < 8)
            sc = $urandom;
        else if (pick == 8)
            sc = $urandom_range(0, 1) ? SCORE_MIN : SCORE_MAX;
        else
            sc = $urandom_range(0, 1) ? '0 : '1;
        send_item(($urandom_range(0, 99) < drain_pct) ? OP_DRAIN : OP_OFFER, $urandom, sc);
    endtask

    // keep count write once the block is idle
    task automatic write_keep(input logic [COUNT_W-1:0] value);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_keep(value);
        cfg_writes++;
    endtask

    // stimulus
    initial
    begin
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        opcode     <= OP_OFFER;
        item_index <= '0;
        score      <= '0;
        no_gaps    = 1'b0;
        hold_armed = 1'b0;
        cfg_writes = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty drain, extremes of index and score, ties kept in arrival order
        send_item(OP_DRAIN, '0, '0);
        send_item(OP_OFFER, 32'h0000_0000, SCORE_MAX);
        send_item(OP_OFFER, 32'hFFFF_FFFF, SCORE_MIN);
        send_item(OP_OFFER, 32'd1, '0);
        send_item(OP_OFFER, 32'd2, -32'sd1);
        send_item(OP_OFFER, 32'd3, 32'sh0001_0000);
        send_item(OP_OFFER, 32'd4, '0);
        send_item(OP_OFFER, 32'd6, SCORE_MIN);
        send_item(OP_DRAIN, 32'hFFFF_FFFF, SCORE_MAX);

        // keep one: equal score rejected, strictly smaller replaces
        write_keep(KEEP_MIN);
        send_item(OP_OFFER, 32'd10, 32'sd5);
        send_item(OP_OFFER, 32'd11, 32'sd5);
        send_item(OP_OFFER, 32'd12, 32'sd6);
        send_item(OP_OFFER, 32'd13, 32'sd4);
        send_item(OP_DRAIN, '0, '0);

        // keep zero acts as keep one
        write_keep('0);
        send_item(OP_OFFER, 32'd20, -32'sd3);
        send_item(OP_OFFER, 32'd22, -32'sd4);
        send_item(OP_DRAIN, '0, '0);

        // lowering the keep count evicts nothing
        write_keep(7'd5);
        for (int i = 0; i < 5; i++)
            send_item(OP_OFFER, 32'd30 + i, 32'sd100 - i);
        write_keep(7'd2);
        send_item(OP_OFFER, 32'd40, 32'sd97);
        send_item(OP_OFFER, 32'd41, 32'sd200);
        send_item(OP_DRAIN, '0, '0);

        // keep count above capacity acts as capacity; receiver holds off long
        write_keep('1);
        hold_armed = 1'b1;
        repeat (66) send_random(0);
        send_item(OP_DRAIN, $urandom, $urandom);
        repeat (5) send_random(0);
        send_item(OP_DRAIN, $urandom, $urandom);

        // full capacity with no idling on either side
        write_keep(KEEP_MAX);
        no_gaps = 1'b1;
        repeat (20) send_random(8);
        send_item(OP_DRAIN, $urandom, $urandom);
        no_gaps = 1'b0;

        // random keep counts, mostly small
        repeat (2)
        begin
            write_keep(COUNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                             : $urandom_range(1, 8)));
            repeat ($urandom_range(4, 8)) send_random(10);
            send_item(OP_DRAIN, $urandom, $urandom);
        end

        // let the last drain finish
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("run: %0d input transfers, %0d drained entries checked, %0d keep count writes",
                 board.transfers, board.checked, cfg_writes);
        if (board.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* bounded_top_k_smallest.f */
rtl/btk_pkg.sv
rtl/btk_cell.sv
rtl/bounded_top_k_smallest.sv
sim/btk_scoreboard_pkg.sv
sim/bounded_top_k_smallest_tb.sv
